@@ sv/nlp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the number literal parser.
package nlp_pkg;

   localparam int unsigned FRAC_DIGITS = 9;

   // character classes
   localparam logic [3:0] CL_ZERO  = 4'd0;
   localparam logic [3:0] CL_DIGIT = 4'd1;
   localparam logic [3:0] CL_X     = 4'd2;
   localparam logic [3:0] CL_POINT = 4'd3;
   localparam logic [3:0] CL_SPACE = 4'd4;
   localparam logic [3:0] CL_NUL   = 4'd5;
   localparam logic [3:0] CL_HEXL  = 4'd6;
   localparam logic [3:0] CL_MINUS = 4'd7;
   localparam logic [3:0] CL_REST  = 4'd8;

   // transition targets: table states, then the two terminal outcomes
   localparam logic [3:0] TG_START      = 4'd0;
   localparam logic [3:0] TG_ZERO       = 4'd1;
   localparam logic [3:0] TG_SPACE      = 4'd2;
   localparam logic [3:0] TG_MINUS      = 4'd3;
   localparam logic [3:0] TG_HEX_PREFIX = 4'd4;
   localparam logic [3:0] TG_HEX_DIGITS = 4'd5;
   localparam logic [3:0] TG_DEC_DIGITS = 4'd6;
   localparam logic [3:0] TG_POINT      = 4'd7;
   localparam logic [3:0] TG_FRAC       = 4'd8;
   localparam logic [3:0] TG_OK         = 4'd9;
   localparam logic [3:0] TG_BAD        = 4'd10;

   localparam int unsigned NUM_STATES  = 9;
   localparam int unsigned NUM_CLASSES = 9;

   localparam logic [3:0] NEXT_TABLE [NUM_STATES][NUM_CLASSES] = '{
      '{TG_ZERO, TG_DEC_DIGITS, TG_HEX_PREFIX, TG_BAD, TG_START, TG_BAD, TG_BAD,
        TG_MINUS, TG_BAD},
      '{TG_DEC_DIGITS, TG_DEC_DIGITS, TG_HEX_PREFIX, TG_POINT, TG_BAD, TG_OK,
        TG_BAD, TG_BAD, TG_BAD},
      '{TG_DEC_DIGITS, TG_DEC_DIGITS, TG_BAD, TG_BAD, TG_SPACE, TG_BAD, TG_BAD,
        TG_BAD, TG_BAD},
      '{TG_DEC_DIGITS, TG_DEC_DIGITS, TG_BAD, TG_BAD, TG_MINUS, TG_BAD, TG_BAD,
        TG_BAD, TG_BAD},
      '{TG_HEX_DIGITS, TG_HEX_DIGITS, TG_BAD, TG_BAD, TG_BAD, TG_BAD,
        TG_HEX_DIGITS, TG_BAD, TG_BAD},
      '{TG_HEX_DIGITS, TG_HEX_DIGITS, TG_BAD, TG_BAD, TG_BAD, TG_OK,
        TG_HEX_DIGITS, TG_BAD, TG_BAD},
      '{TG_DEC_DIGITS, TG_DEC_DIGITS, TG_BAD, TG_POINT, TG_BAD, TG_OK, TG_BAD,
        TG_BAD, TG_BAD},
      '{TG_FRAC, TG_FRAC, TG_BAD, TG_BAD, TG_BAD, TG_BAD, TG_BAD, TG_BAD, TG_BAD},
      '{TG_FRAC, TG_FRAC, TG_BAD, TG_BAD, TG_BAD, TG_OK, TG_BAD, TG_BAD, TG_BAD}
   };

   typedef enum logic [8:0] {
      ST_START      = 9'b000000001,
      ST_ZERO       = 9'b000000010,
      ST_SPACE      = 9'b000000100,
      ST_MINUS      = 9'b000001000,
      ST_HEX_PREFIX = 9'b000010000,
      ST_HEX_DIGITS = 9'b000100000,
      ST_DEC_DIGITS = 9'b001000000,
      ST_POINT      = 9'b010000000,
      ST_FRAC       = 9'b100000000
   } parse_state_type;

   typedef struct packed {
      parse_state_type state;
      logic [31:0]     int_accum;
      logic [29:0]     frac_accum;
      logic [3:0]      frac_kept;
      logic            minus;
      logic            saw_dec;
      logic            saw_hex;
      logic            saw_real;
      logic            overflow;
      logic            skip;
   } ctx_type;

   typedef struct packed {
      logic        is_invalid;
      logic        saw_decimal;
      logic        saw_hex;
      logic        saw_real;
      logic        negative;
      logic [31:0] int_part;
      logic [29:0] frac_value;
      logic [3:0]  frac_count;
      logic        overflow;
   } result_type;

   localparam ctx_type CTX_RESET = '{
      state:      ST_START,
      int_accum:  32'd0,
      frac_accum: 30'd0,
      frac_kept:  4'd0,
      minus:      1'b0,
      saw_dec:    1'b0,
      saw_hex:    1'b0,
      saw_real:   1'b0,
      overflow:   1'b0,
      skip:       1'b0
   };

   function automatic logic [3:0] char_class(input logic [7:0] c);
      logic [3:0] cls;
      if (c == 8'h30) cls = CL_ZERO;
      else if (c >= 8'h31 && c <= 8'h39) cls = CL_DIGIT;
      else if (c == 8'h78 || c == 8'h58) cls = CL_X;
      else if (c == 8'h2e) cls = CL_POINT;
      else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) cls = CL_SPACE;
      else if (c == 8'h00) cls = CL_NUL;
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) cls = CL_HEXL;
      else if (c == 8'h2d) cls = CL_MINUS;
      else cls = CL_REST;
      return cls;
   endfunction

   // digits map through their low nibble, letters a..f / A..F add nine
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         v = c[3:0] + 4'd9;
      else v = 4'd0;
      return v;
   endfunction

   function automatic logic [3:0] state_index(input parse_state_type s);
      logic [3:0] idx;
      case (s)
         ST_START:      idx = TG_START;
         ST_ZERO:       idx = TG_ZERO;
         ST_SPACE:      idx = TG_SPACE;
         ST_MINUS:      idx = TG_MINUS;
         ST_HEX_PREFIX: idx = TG_HEX_PREFIX;
         ST_HEX_DIGITS: idx = TG_HEX_DIGITS;
         ST_DEC_DIGITS: idx = TG_DEC_DIGITS;
         ST_POINT:      idx = TG_POINT;
         ST_FRAC:       idx = TG_FRAC;
         default:       idx = TG_START;
      endcase
      return idx;
   endfunction

   function automatic parse_state_type state_from_target(input logic [3:0] t);
      parse_state_type s;
      case (t)
         TG_ZERO:       s = ST_ZERO;
         TG_SPACE:      s = ST_SPACE;
         TG_MINUS:      s = ST_MINUS;
         TG_HEX_PREFIX: s = ST_HEX_PREFIX;
         TG_HEX_DIGITS: s = ST_HEX_DIGITS;
         TG_DEC_DIGITS: s = ST_DEC_DIGITS;
         TG_POINT:      s = ST_POINT;
         TG_FRAC:       s = ST_FRAC;
         default:       s = ST_START;
      endcase
      return s;
   endfunction

endpackage

@@ sv/nlp_step.sv @@
`timescale 1ns / 1ps
// One-character update of the parser context and result formation.
module nlp_step #(
   parameter int unsigned FRAC_DIGITS = nlp_pkg::FRAC_DIGITS
) (
   input  logic [7:0]          ch,
   input  nlp_pkg::ctx_type    cur,
   output nlp_pkg::ctx_type    nxt,
   output logic                emit,
   output nlp_pkg::result_type res
);
   import nlp_pkg::*;

   logic [3:0]  cls;
   logic [3:0]  target;
   logic [3:0]  digit_hex;
   logic [3:0]  digit_dec;
   logic [35:0] dec_sum;
   logic [35:0] hex_sum;
   logic [33:0] frac_sum;

   assign cls       = char_class(ch);
   assign digit_hex = hex_value(ch);
   assign digit_dec = ch[3:0];

   // x*10 = x*8 + x*2
   assign dec_sum  = {1'b0, cur.int_accum, 3'b000} + {3'b000, cur.int_accum, 1'b0}
                   + {32'd0, digit_dec};
   assign hex_sum  = {cur.int_accum, digit_hex};
   assign frac_sum = {1'b0, cur.frac_accum, 3'b000} + {3'b000, cur.frac_accum, 1'b0}
                   + {30'd0, digit_dec};

   always_comb begin
      nxt    = cur;
      emit   = 1'b0;
      res    = '0;
      target = TG_START;
      if (cur.skip) begin
         if (ch == 8'h00) begin
            nxt = CTX_RESET;
         end
      end else begin
         target = NEXT_TABLE[state_index(cur.state)][cls];
         case (target)
            TG_MINUS: begin
               nxt.minus = 1'b1;
            end
            TG_HEX_PREFIX: begin
               nxt.saw_hex = 1'b1;
            end
            TG_HEX_DIGITS: begin
               nxt.int_accum = hex_sum[31:0];
               if (hex_sum[35:32] != 4'd0) nxt.overflow = 1'b1;
            end
            TG_DEC_DIGITS: begin
               nxt.saw_dec   = 1'b1;
               nxt.int_accum = dec_sum[31:0];
               if (dec_sum[35:32] != 4'd0) nxt.overflow = 1'b1;
            end
            TG_POINT: begin
               nxt.saw_real = 1'b1;
            end
            TG_FRAC: begin
               if (cur.frac_kept < 4'(FRAC_DIGITS)) begin
                  nxt.frac_accum = frac_sum[29:0];
                  nxt.frac_kept  = cur.frac_kept + 4'd1;
               end else begin
                  nxt.overflow = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (target == TG_OK) begin
            emit            = 1'b1;
            res.saw_decimal = cur.saw_dec;
            res.saw_hex     = cur.saw_hex;
            res.saw_real    = cur.saw_real;
            res.negative    = cur.minus;
            res.int_part    = cur.int_accum;
            res.frac_value  = cur.frac_accum;
            res.frac_count  = cur.frac_kept;
            res.overflow    = cur.overflow;
            nxt             = CTX_RESET;
         end else if (target == TG_BAD) begin
            emit           = 1'b1;
            res.is_invalid = 1'b1;
            nxt            = CTX_RESET;
            nxt.skip       = (ch != 8'h00);
         end else begin
            nxt.state = state_from_target(target);
         end
      end
   end

endmodule

@@ sv/number_literal_parser_top.sv @@
`timescale 1ns / 1ps
// Top level of the number literal parser: request register, context, result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_ch (8b character, 0 ends text)
//   rsp     | out       | rsp_valid/rsp_ready  | flags, int_part, frac_value/count, overflow
//
// One character per cycle unless a held result stalls it. A request is registered in
// the input register, is applied to the context, and its result (if any) is
// registered and shows on rsp. The context update in nlp_step is the combinational loop.
// Synchronous reset clears context and both valid flags.
// A held result stalls the input register; req_ready drops only while both are
// full and rsp_ready is low.
module number_literal_parser_top #(
   parameter int unsigned FRAC_DIGITS = nlp_pkg::FRAC_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_invalid,
   output logic        rsp_saw_decimal,
   output logic        rsp_saw_hex,
   output logic        rsp_saw_real,
   output logic        rsp_negative,
   output logic [31:0] rsp_int_part,
   output logic [29:0] rsp_frac_value,
   output logic [3:0]  rsp_frac_count,
   output logic        rsp_overflow
);
   import nlp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff, in_ch_in;
   ctx_type    ctx_ff, ctx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   ctx_type    step_ctx;
   logic       step_emit;
   result_type step_res;
   logic       advance;

   nlp_step #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_step (
      .ch   (in_ch_ff),
      .cur  (ctx_ff),
      .nxt  (step_ctx),
      .emit (step_emit),
      .res  (step_res)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_ch_in     = in_ch_ff;
      ctx_in       = ctx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (advance) begin
         ctx_in      = step_ctx;
         in_valid_in = 1'b0;
         if (step_emit) begin
            rsp_valid_in = 1'b1;
            rsp_in       = step_res;
         end
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_ch_in    = req_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctx_ff       <= CTX_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctx_ff       <= ctx_in;
      end
      in_ch_ff <= in_ch_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_invalid  = rsp_ff.is_invalid;
   assign rsp_saw_decimal = rsp_ff.saw_decimal;
   assign rsp_saw_hex     = rsp_ff.saw_hex;
   assign rsp_saw_real    = rsp_ff.saw_real;
   assign rsp_negative    = rsp_ff.negative;
   assign rsp_int_part    = rsp_ff.int_part;
   assign rsp_frac_value  = rsp_ff.frac_value;
   assign rsp_frac_count  = rsp_ff.frac_count;
   assign rsp_overflow    = rsp_ff.overflow;

   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_invalid |->
         rsp_ff.int_part == '0 && rsp_ff.frac_value == '0 && rsp_ff.frac_count == '0
         && !rsp_ff.overflow && !rsp_ff.negative && !rsp_ff.saw_hex)
      else $error("invalid result carries nonzero fields");

   a_frac_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.frac_count <= 4'(FRAC_DIGITS))
      else $error("fraction digit count above cap");

   a_frac_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frac_count == 4'd0 |-> rsp_ff.frac_value == '0)
      else $error("fraction value without digits");

   a_hex_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.saw_hex && (rsp_ff.saw_decimal || rsp_ff.saw_real)))
      else $error("hex result also flagged decimal or real");

   a_skip_clear: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.skip |-> ctx_ff.state == ST_START && ctx_ff.int_accum == '0
         && ctx_ff.frac_kept == '0)
      else $error("context not cleared while dropping characters");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for number_literal_parser_top: character streams checked against an in-bench parser.
module tb_top;
   import nlp_pkg::*;

   localparam int QUIET_LIMIT = 20000;

   // next target per parse state and character class
   localparam logic [3:0] TRANSITIONS [9][9] = '{
      '{TG_ZERO, TG_DEC_DIGITS, TG_HEX_PREFIX, TG_BAD, TG_START, TG_BAD, TG_BAD,
        TG_MINUS, TG_BAD},
      '{TG_DEC_DIGITS, TG_DEC_DIGITS, TG_HEX_PREFIX, TG_POINT, TG_BAD, TG_OK,
        TG_BAD, TG_BAD, TG_BAD},
      '{TG_DEC_DIGITS, TG_DEC_DIGITS, TG_BAD, TG_BAD, TG_SPACE, TG_BAD, TG_BAD,
        TG_BAD, TG_BAD},
      '{TG_DEC_DIGITS, TG_DEC_DIGITS, TG_BAD, TG_BAD, TG_MINUS, TG_BAD, TG_BAD,
        TG_BAD, TG_BAD},
      '{TG_HEX_DIGITS, TG_HEX_DIGITS, TG_BAD, TG_BAD, TG_BAD, TG_BAD,
        TG_HEX_DIGITS, TG_BAD, TG_BAD},
      '{TG_HEX_DIGITS, TG_HEX_DIGITS, TG_BAD, TG_BAD, TG_BAD, TG_OK,
        TG_HEX_DIGITS, TG_BAD, TG_BAD},
      '{TG_DEC_DIGITS, TG_DEC_DIGITS, TG_BAD, TG_POINT, TG_BAD, TG_OK, TG_BAD,
        TG_BAD, TG_BAD},
      '{TG_FRAC, TG_FRAC, TG_BAD, TG_BAD, TG_BAD, TG_BAD, TG_BAD, TG_BAD, TG_BAD},
      '{TG_FRAC, TG_FRAC, TG_BAD, TG_BAD, TG_BAD, TG_OK, TG_BAD, TG_BAD, TG_BAD}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_invalid;
   logic        rsp_saw_decimal;
   logic        rsp_saw_hex;
   logic        rsp_saw_real;
   logic        rsp_negative;
   logic [31:0] rsp_int_part;
   logic [29:0] rsp_frac_value;
   logic [3:0]  rsp_frac_count;
   logic        rsp_overflow;

   // parser copy
   logic [3:0]  prs_state;
   logic [31:0] int_acc;
   logic [29:0] frac_acc;
   logic [3:0]  frac_kept;
   logic        minus_flag, dec_flag, hex_flag, real_flag, ovf_flag, dropping;

   result_type  parsed_due[$];
   logic [7:0]  text_buf[$];
   int          taken_chars = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   int          gap_pct = 0;
   int          stall_pct = 0;

   number_literal_parser_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_invalid (rsp_is_invalid),
      .rsp_saw_decimal(rsp_saw_decimal),
      .rsp_saw_hex    (rsp_saw_hex),
      .rsp_saw_real   (rsp_saw_real),
      .rsp_negative   (rsp_negative),
      .rsp_int_part   (rsp_int_part),
      .rsp_frac_value (rsp_frac_value),
      .rsp_frac_count (rsp_frac_count),
      .rsp_overflow   (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void clear_parse();
      prs_state  = TG_START;
      int_acc    = '0;
      frac_acc   = '0;
      frac_kept  = '0;
      minus_flag = 1'b0;
      dec_flag   = 1'b0;
      hex_flag   = 1'b0;
      real_flag  = 1'b0;
      ovf_flag   = 1'b0;
      dropping   = 1'b0;
   endfunction

   initial clear_parse();

   function automatic void add_char(input logic [7:0] c);
      text_buf = {text_buf, c};
   endfunction

   function automatic logic [3:0] class_of(input logic [7:0] c);
      if (c == 8'h00) return CL_NUL;
      if (c == "-") return CL_MINUS;
      if (c == ".") return CL_POINT;
      if (c == "0") return CL_ZERO;
      if (c >= "1" && c <= "9") return CL_DIGIT;
      if (c == "x" || c == "X") return CL_X;
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return CL_SPACE;
      if ((c | 8'h20) >= "a" && (c | 8'h20) <= "f") return CL_HEXL;
      return CL_REST;
   endfunction

   function automatic void fold_int(input logic [4:0] radix, input logic [7:0] c);
      logic [63:0] v;
      logic [7:0]  d;
      d = (c <= "9") ? c - "0" : (c | 8'h20) - "a" + 8'd10;
      v = {32'd0, int_acc} * {59'd0, radix} + {56'd0, d};
      if (v[63:32] != '0) ovf_flag = 1'b1;
      int_acc = v[31:0];
   endfunction

   function automatic void predict_parse(input logic [7:0] c);
      logic [3:0] nxt;
      result_type r;
      if (dropping) begin
         if (c == 8'h00) clear_parse();
         return;
      end
      taken_chars++;
      nxt = TRANSITIONS[prs_state][class_of(c)];
      case (nxt)
         TG_MINUS:      minus_flag = 1'b1;
         TG_HEX_PREFIX: hex_flag = 1'b1;
         TG_HEX_DIGITS: fold_int(5'd16, c);
         TG_DEC_DIGITS: begin
            dec_flag = 1'b1;
            fold_int(5'd10, c);
         end
         TG_POINT:      real_flag = 1'b1;
         TG_FRAC: begin
            if (frac_kept < FRAC_DIGITS) begin
               frac_acc  = frac_acc * 30'd10 + {22'd0, c - 8'h30};
               frac_kept = frac_kept + 4'd1;
            end else begin
               ovf_flag = 1'b1;
            end
         end
         default: ;
      endcase
      r = '0;
      if (nxt == TG_OK) begin
         r.saw_decimal = dec_flag;
         r.saw_hex     = hex_flag;
         r.saw_real    = real_flag;
         r.negative    = minus_flag;
         r.int_part    = int_acc;
         r.frac_value  = frac_acc;
         r.frac_count  = frac_kept;
         r.overflow    = ovf_flag;
         parsed_due = {parsed_due, r};
         clear_parse();
      end else if (nxt == TG_BAD) begin
         r.is_invalid = 1'b1;
         parsed_due = {parsed_due, r};
         clear_parse();
         dropping = (c != 8'h00);
      end else begin
         prs_state = nxt;
      end
   endfunction

   function automatic string fmt_result(input result_type r);
      return {$sformatf("inv=%0b dec=%0b hex=%0b real=%0b neg=%0b ", r.is_invalid,
                        r.saw_decimal, r.saw_hex, r.saw_real, r.negative),
              $sformatf("int=%08h frac=%0d cnt=%0d ovf=%0b", r.int_part, r.frac_value,
                        r.frac_count, r.overflow)};
   endfunction

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (!req_ready);
      predict_parse(c);
   endtask

   task automatic send_text();
      add_char(8'h00);
      foreach (text_buf[i]) send_char(text_buf[i]);
      text_buf.delete();
   endtask

   task automatic queue_str(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic send_literal(input string s);
      queue_str(s);
      send_text();
   endtask

   function automatic logic [7:0] pick_digit(input bit nonzero);
      return nonzero ? 8'(8'h30 + $urandom_range(1, 9)) : 8'(8'h30 + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_hex_char();
      int unsigned r;
      r = $urandom_range(21);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 16) return 8'(8'h61 + r - 10);
      return 8'(8'h41 + r - 16);
   endfunction

   function automatic logic [7:0] pick_space();
      int unsigned r;
      r = $urandom_range(9, 14);
      return (r == 14) ? 8'h20 : r[7:0];
   endfunction

   task automatic build_decimal();
      int n;
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) add_char(pick_space());
      if ($urandom_range(9) < 3) begin
         add_char("-");
         if ($urandom_range(3) == 0) add_char(pick_space());
      end
      n = ($urandom_range(4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
      add_char(($urandom_range(6) == 0) ? 8'h30 : pick_digit(1'b1));
      repeat (n - 1) add_char(pick_digit(1'b0));
   endtask

   task automatic build_hex();
      int n;
      if ($urandom_range(4) == 0) add_char(pick_space());
      case ($urandom_range(3))
         0: queue_str("0x");
         1: queue_str("0X");
         2: queue_str("x");
         default: queue_str("X");
      endcase
      n = ($urandom_range(4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      repeat (n) add_char(pick_hex_char());
   endtask

   task automatic build_real();
      int n;
      if ($urandom_range(9) < 3) add_char("-");
      add_char(pick_digit(1'b0));
      repeat ($urandom_range(0, 3)) add_char(pick_digit(1'b0));
      add_char(".");
      n = ($urandom_range(3) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 6);
      repeat (n) add_char(pick_digit(1'b0));
   endtask

   task automatic build_any();
      case ($urandom_range(2))
         0: build_decimal();
         1: build_hex();
         default: build_real();
      endcase
   endtask

   task automatic test_directed();
      send_literal("");
      send_literal("-");
      send_literal("7.");
      send_literal("0");
      send_literal("xfF");
      add_char(8'hFF);
      send_literal("9");
      send_literal("\t-0.9");
   endtask

   task automatic test_decimal(input int budget);
      int stop;
      stop = taken_chars + budget;
      while (taken_chars < stop) begin
         build_decimal();
         send_text();
      end
   endtask

   task automatic test_hex(input int budget);
      int stop;
      stop = taken_chars + budget;
      while (taken_chars < stop) begin
         build_hex();
         send_text();
      end
   endtask

   task automatic test_real(input int budget);
      int stop;
      stop = taken_chars + budget;
      while (taken_chars < stop) begin
         build_real();
         send_text();
      end
   endtask

   task automatic test_malformed(input int budget);
      int stop;
      int pos;
      stop = taken_chars + budget;
      while (taken_chars < stop) begin
         case ($urandom_range(3))
            0: repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(255)));
            1: begin
               build_any();
               pos = $urandom_range(text_buf.size() - 1);
               text_buf[pos] = 8'($urandom_range(255));
            end
            2: begin
               build_any();
               add_char(($urandom_range(1) == 0) ? pick_space()
                                                 : 8'(8'h80 + $urandom_range(127)));
            end
            default: begin
               case ($urandom_range(3))
                  0: queue_str("-");
                  1: queue_str("5.");
                  2: queue_str("0x");
                  default: queue_str("- ");
               endcase
            end
         endcase
         send_text();
      end
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.is_invalid  = rsp_is_invalid;
         got.saw_decimal = rsp_saw_decimal;
         got.saw_hex     = rsp_saw_hex;
         got.saw_real    = rsp_saw_real;
         got.negative    = rsp_negative;
         got.int_part    = rsp_int_part;
         got.frac_value  = rsp_frac_value;
         got.frac_count  = rsp_frac_count;
         got.overflow    = rsp_overflow;
         if (parsed_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result: %s", fmt_result(got));
         end else begin
            want = parsed_due.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch: expected %s", fmt_result(want));
                  $display("          actual   %s", fmt_result(got));
               end
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 66; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 66; end
            default: begin gap_pct = 6; stall_pct = 6; end
         endcase
         test_decimal(60);
         test_hex(45);
         test_real(55);
         test_malformed(40);
      end
      req_valid <= 1'b0;
      while (parsed_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
sv/nlp_pkg.sv
sv/nlp_step.sv
sv/number_literal_parser_top.sv
dv/tb_top.sv
